/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CESC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cesc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CESC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cesc: next-cycle check failed");

`endif

/* rtl/cesc_pkg.sv */
`default_nettype none

package cesc_pkg;

    // Item field widths
    localparam int ARM_W    = 2;
    localparam int SECTOR_W = 3;
    localparam int IDX_W    = 5;
    localparam int LOC_W    = 3;
    localparam int NUM_LOC  = 8;

    localparam logic [ARM_W-1:0]    ARM_EAST           = 2'd1;
    localparam logic [SECTOR_W-1:0] FIRST_SECTOR_LIMIT = 3'd2;
    localparam logic [IDX_W-1:0]    LAST_LOC           = 5'd7;

    // Datapath widths
    localparam int RATE_W = 26;   // base-2 decay rate, Q24
    localparam int AMP_W  = 28;   // amplitude, Q30
    localparam int FACT_W = 31;   // factor, Q30
    localparam int CORR_W = 31;   // combined factor, Q30
    localparam int U_W    = 30;   // Horner argument, Q30
    localparam int P_W    = 31;   // Horner value, Q30, up to 1.0
    localparam int FRAC_W = 24;   // exponent fraction bits

    localparam int HORNER_TERMS = 8;
    localparam int STEP_LAT     = 3;
    localparam int DECAY_LAT    = 2 + HORNER_TERMS * STEP_LAT + 1;

    localparam logic [P_W-1:0] Q30_ONE   = 31'h4000_0000;
    localparam logic [29:0]    LN2_Q30   = 30'd744261118;
    localparam logic [63:0]    LOG2E_Q30 = 64'd1549082005;

    localparam logic [63:0] E7      = 64'd10000000;
    localparam logic [63:0] E7_HALF = 64'd5000000;

    // First factor (east arm, low sectors)
    localparam logic [FACT_W-1:0] FIRST_BASE =
        FACT_W'(((64'd9629440 << 30) + E7_HALF) / E7);
    localparam logic [AMP_W-1:0] FIRST_AMP =
        AMP_W'(((64'd1356440 << 30) + E7_HALF) / E7);
    localparam logic [RATE_W-1:0] FIRST_RATE =
        RATE_W'(((((64'd11090400 << 30) + E7_HALF) / E7) * LOG2E_Q30) >> 36);

    // Second factor, one entry per location
    localparam logic [FACT_W-1:0] SEC_BASE [NUM_LOC] = '{
        FACT_W'(((64'd10000000 << 30) + E7_HALF) / E7),
        FACT_W'(((64'd9870040  << 30) + E7_HALF) / E7),
        FACT_W'(((64'd9676630  << 30) + E7_HALF) / E7),
        FACT_W'(((64'd9615090  << 30) + E7_HALF) / E7),
        FACT_W'(((64'd10000000 << 30) + E7_HALF) / E7),
        FACT_W'(((64'd10000000 << 30) + E7_HALF) / E7),
        FACT_W'(((64'd9392700  << 30) + E7_HALF) / E7),
        FACT_W'(((64'd9413850  << 30) + E7_HALF) / E7)
    };

    localparam logic [AMP_W-1:0] SEC_AMP [NUM_LOC] = '{
        AMP_W'(0),
        AMP_W'(((64'd200000 << 30) + E7_HALF) / E7),
        AMP_W'(((64'd200000 << 30) + E7_HALF) / E7),
        AMP_W'(((64'd400000 << 30) + E7_HALF) / E7),
        AMP_W'(0),
        AMP_W'(0),
        AMP_W'(((64'd603399 << 30) + E7_HALF) / E7),
        AMP_W'(((64'd437485 << 30) + E7_HALF) / E7)
    };

    localparam logic [RATE_W-1:0] SEC_RATE [NUM_LOC] = '{
        RATE_W'(0),
        RATE_W'(((((64'd12087600 << 30) + E7_HALF) / E7) * LOG2E_Q30) >> 36),
        RATE_W'(((((64'd9764880  << 30) + E7_HALF) / E7) * LOG2E_Q30) >> 36),
        RATE_W'(((((64'd14281200 << 30) + E7_HALF) / E7) * LOG2E_Q30) >> 36),
        RATE_W'(0),
        RATE_W'(0),
        RATE_W'(((((64'd16024900 << 30) + E7_HALF) / E7) * LOG2E_Q30) >> 36),
        RATE_W'(((((64'd10380200 << 30) + E7_HALF) / E7) * LOG2E_Q30) >> 36)
    };

endpackage

`default_nettype wire

/* rtl/cesc_horner_step.sv */
`default_nettype none

// One Horner step: p_out = 1 - ((u*p) >> 30) / DIVISOR, three stages.
module cesc_horner_step #(
    parameter int DIVISOR = 8
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [cesc_pkg::U_W-1:0]    u_in,
    input  logic [cesc_pkg::P_W-1:0]    p_in,
    output logic [cesc_pkg::U_W-1:0]    u_out,
    output logic [cesc_pkg::P_W-1:0]    p_out
);
    import cesc_pkg::*;

    localparam int PA_W = U_W + P_W;
    localparam int PB_W = U_W + 33;
    localparam int DW   = U_W + 4;
    // floor(2^32 / D): estimate is low by at most one
    localparam logic [32:0]   RECIP   = 33'((64'd1 << 32) / DIVISOR);
    localparam logic [DW-1:0] DIV_EXT = DW'(DIVISOR);

    logic [U_W-1:0] xa_reg, ua_reg;
    logic [U_W-1:0] qb_reg, xb_reg, ub_reg;
    logic [P_W-1:0] pc_reg;
    logic [U_W-1:0] uc_reg;

    logic [PA_W-1:0] prod_a;
    logic [PB_W-1:0] prod_b;
    logic [DW-1:0]   qd, rem;
    logic [U_W-1:0]  q;
    logic [P_W-1:0]  p_next;

    assign prod_a = PA_W'(u_in) * PA_W'(p_in);
    assign prod_b = PB_W'(xa_reg) * PB_W'(RECIP);

    always_comb begin
        qd     = DW'(qb_reg) * DIV_EXT;
        rem    = DW'(xb_reg) - qd;
        q      = qb_reg + U_W'(rem >= DIV_EXT);
        p_next = Q30_ONE - P_W'(q);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xa_reg <= prod_a[30 +: U_W];
            ua_reg <= u_in;
            qb_reg <= prod_b[32 +: U_W];
            xb_reg <= xa_reg;
            ub_reg <= ua_reg;
            pc_reg <= p_next;
            uc_reg <= ub_reg;
        end
    end

    assign u_out = uc_reg;
    assign p_out = pc_reg;

endmodule

`default_nettype wire

/* rtl/cesc_decay.sv */
`default_nettype none

// exp(-rate*E) in Q30, rate given base 2 in Q24.
module cesc_decay #(
    parameter int ENERGY_WIDTH     = 24,
    parameter int ENERGY_FRAC_BITS = 18
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [cesc_pkg::RATE_W-1:0]   rate,
    input  logic [ENERGY_WIDTH-1:0]       energy,
    output logic [cesc_pkg::P_W-1:0]      expq
);
    import cesc_pkg::*;

    localparam int Y_W         = RATE_W + ENERGY_WIDTH;
    localparam int UP_W        = FRAC_W + 30;
    localparam int SCALE_DEPTH = 2 + HORNER_TERMS * STEP_LAT;

    typedef struct packed {
        logic       zero;
        logic [4:0] shift;
    } scale_t;

    logic [Y_W-1:0]    prod_y, y_sh, n_big;
    scale_t            scale_next;
    scale_t            scale_reg [SCALE_DEPTH];
    logic [FRAC_W-1:0] f_reg;
    logic [UP_W-1:0]   prod_u;
    logic [U_W-1:0]    u_reg;
    logic [U_W-1:0]    u_chain [HORNER_TERMS];
    logic [P_W-1:0]    p_chain [HORNER_TERMS+1];
    logic [P_W-1:0]    expq_next, expq_reg;

    // Stage 1: exponent, split into integer and fraction
    always_comb begin
        prod_y           = Y_W'(rate) * Y_W'(energy);
        y_sh             = prod_y >> ENERGY_FRAC_BITS;
        n_big            = y_sh >> FRAC_W;
        scale_next.zero  = n_big > Y_W'(30);
        scale_next.shift = n_big[4:0];
    end

    // Stage 2: fraction to natural-log argument
    assign prod_u = UP_W'(f_reg) * UP_W'(LN2_Q30);

    always_ff @(posedge aclk) begin
        if (en) begin
            f_reg        <= y_sh[FRAC_W-1:0];
            u_reg        <= prod_u[FRAC_W +: U_W];
            scale_reg[0] <= scale_next;
            for (int i = 1; i < SCALE_DEPTH; i++) begin
                scale_reg[i] <= scale_reg[i-1];
            end
        end
    end

    assign u_chain[0] = u_reg;
    assign p_chain[0] = Q30_ONE;

    for (genvar k = 0; k < HORNER_TERMS; k++) begin : g_step
        if (k < HORNER_TERMS - 1) begin : g_mid
            cesc_horner_step #(.DIVISOR(HORNER_TERMS - k)) u_step (
                .aclk  (aclk),
                .en    (en),
                .u_in  (u_chain[k]),
                .p_in  (p_chain[k]),
                .u_out (u_chain[k+1]),
                .p_out (p_chain[k+1])
            );
        end else begin : g_last
            cesc_horner_step #(.DIVISOR(HORNER_TERMS - k)) u_step (
                .aclk  (aclk),
                .en    (en),
                .u_in  (u_chain[k]),
                .p_in  (p_chain[k]),
                .u_out (),
                .p_out (p_chain[k+1])
            );
        end
    end

    // Final stage: scale by 2^-n, underflow to zero
    always_comb begin
        if (scale_reg[SCALE_DEPTH-1].zero) begin
            expq_next = '0;
        end else begin
            expq_next = p_chain[HORNER_TERMS] >> scale_reg[SCALE_DEPTH-1].shift;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            expq_reg <= expq_next;
        end
    end

    assign expq = expq_reg;

endmodule

`default_nettype wire

/* rtl/cesc_out_skid.sv */
`default_nettype none

`include "assert_macros.svh"

// Two-entry output buffer; full is registered so the pipeline stall
// does not depend on the downstream ready.
module cesc_out_skid #(
    parameter int WIDTH = 25
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [WIDTH-1:0] m_data
);
    localparam logic [1:0] CNT_EMPTY = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_FULL  = 2'd2;

    logic [1:0]       cnt_reg, cnt_next;
    logic [WIDTH-1:0] head_reg, tail_reg;
    logic             pop;

    assign m_valid = cnt_reg != CNT_EMPTY;
    assign full    = cnt_reg == CNT_FULL;
    assign pop     = m_valid && m_ready;
    assign m_data  = head_reg;

    always_comb begin
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= CNT_EMPTY;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && (cnt_reg == CNT_EMPTY || (cnt_reg == CNT_ONE && pop))) begin
            head_reg <= push_data;
        end else if (pop && cnt_reg == CNT_FULL) begin
            head_reg <= tail_reg;
        end
        if (push && cnt_reg == CNT_ONE && !pop) begin
            tail_reg <= push_data;
        end
    end

    `CESC_ASSERT_IMP(a_no_overfill, aclk, aresetn, push, !full)
    `CESC_ASSERT_NXT(a_full_holds, aclk, aresetn, full && !m_ready, full && $stable(m_data))

endmodule

`default_nettype wire

/* rtl/cluster_energy_scale_correction_unit.sv */
// Path: an accepted item passes the input register, the exponential pipeline, three multiply
//   stages and the output buffer before it shows on m_tvalid.
// Throughput: one item per cycle; the 8-term Horner pipeline (3 stages per term)
//   sets the depth, and s_tready drops only while the 2-entry output buffer is full.
// Reset: aresetn, synchronous, active low; clears all stage valid bits and the
//   output buffer count. Datapath registers are not reset.
`default_nettype none

`include "assert_macros.svh"

module cluster_energy_scale_correction_unit #(
    parameter  int ENERGY_WIDTH     = 24,
    parameter  int ENERGY_FRAC_BITS = 18,
    localparam int S_TDATA_W        = ((ENERGY_WIDTH + 5 + 7) / 8) * 8,
    localparam int M_TDATA_W        = ((ENERGY_WIDTH + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata, low bit up: arm_index[1:0], sector_index[2:0],
    //   energy_in[ENERGY_WIDTH-1:0], zero fill
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // m_tdata, low bit up: energy_out[ENERGY_WIDTH-1:0], zero fill
    // m_tuser: bad_location
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [0:0]           m_tuser
);
    import cesc_pkg::*;

    localparam int EW      = ENERGY_WIDTH;
    localparam int PF_W    = AMP_W + P_W;
    localparam int PC_W    = 2 * FACT_W;
    localparam int PE_W    = EW + CORR_W;
    localparam int RES_W   = EW + 1;

    // Sideband carried alongside the exponential pipeline
    typedef struct packed {
        logic             bad;
        logic             use_first;
        logic [LOC_W-1:0] loc;
        logic [EW-1:0]    energy;
    } side_t;

    // ---------------------------------------------------------------
    // Stall control: whole pipeline moves unless the tail holds an
    // item and the output buffer cannot take it.
    // ---------------------------------------------------------------
    logic en;
    logic buf_full;
    logic r_valid_reg;

    assign en       = !r_valid_reg || !buf_full;
    assign s_tready = en;

    // ---------------------------------------------------------------
    // Stage 0: unpack, location decode, rate lookup
    // ---------------------------------------------------------------
    logic [ARM_W-1:0]    arm;
    logic [SECTOR_W-1:0] sector;
    logic [EW-1:0]       energy_in;
    logic [IDX_W-1:0]    idx;
    side_t               s0_side_next, s0_side_reg;
    logic                s0_valid_reg;
    logic [RATE_W-1:0]   s0_rate_reg;

    assign arm       = s_tdata[1:0];
    assign sector    = s_tdata[4:2];
    assign energy_in = s_tdata[5 +: EW];

    always_comb begin
        idx                    = {1'b0, arm, 2'b00} + IDX_W'(sector);
        s0_side_next.bad       = idx > LAST_LOC;
        s0_side_next.use_first = (arm == ARM_EAST) && (sector < FIRST_SECTOR_LIMIT);
        s0_side_next.loc       = idx[LOC_W-1:0];
        s0_side_next.energy    = energy_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (en) begin
            s0_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_side_reg <= s0_side_next;
            s0_rate_reg <= SEC_RATE[idx[LOC_W-1:0]];
        end
    end

    // ---------------------------------------------------------------
    // Exponentials: one unit per factor, same energy
    // ---------------------------------------------------------------
    logic [P_W-1:0] expq1, expq2;

    cesc_decay #(
        .ENERGY_WIDTH     (ENERGY_WIDTH),
        .ENERGY_FRAC_BITS (ENERGY_FRAC_BITS)
    ) u_decay_first (
        .aclk   (aclk),
        .en     (en),
        .rate   (FIRST_RATE),
        .energy (s0_side_reg.energy),
        .expq   (expq1)
    );

    cesc_decay #(
        .ENERGY_WIDTH     (ENERGY_WIDTH),
        .ENERGY_FRAC_BITS (ENERGY_FRAC_BITS)
    ) u_decay_second (
        .aclk   (aclk),
        .en     (en),
        .rate   (s0_rate_reg),
        .energy (s0_side_reg.energy),
        .expq   (expq2)
    );

    // Sideband delay matching the exponential latency
    logic [DECAY_LAT-1:0] dl_valid_reg;
    side_t                dl_side_reg [DECAY_LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dl_valid_reg <= '0;
        end else if (en) begin
            dl_valid_reg <= {dl_valid_reg[DECAY_LAT-2:0], s0_valid_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dl_side_reg[0] <= s0_side_reg;
            for (int i = 1; i < DECAY_LAT; i++) begin
                dl_side_reg[i] <= dl_side_reg[i-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage F: first factor is 1.0 unless used, else each factor = base + (amp * exp) >> 30
    // ---------------------------------------------------------------
    side_t               dl_tail;
    logic [PF_W-1:0]     prod_f1, prod_f2;
    logic [FACT_W-1:0]   f1_next, f2_next, f1_reg, f2_reg;
    logic                f_valid_reg, f_bad_reg;
    logic [EW-1:0]       f_energy_reg;

    assign dl_tail = dl_side_reg[DECAY_LAT-1];

    always_comb begin
        prod_f1 = PF_W'(FIRST_AMP) * PF_W'(expq1);
        prod_f2 = PF_W'(SEC_AMP[dl_tail.loc]) * PF_W'(expq2);
        if (dl_tail.use_first) begin
            f1_next = FIRST_BASE + FACT_W'(prod_f1 >> 30);
        end else begin
            f1_next = Q30_ONE;
        end
        f2_next = SEC_BASE[dl_tail.loc] + FACT_W'(prod_f2 >> 30);
    end

    // ---------------------------------------------------------------
    // Stage C: combined factor, rounded Q30
    // ---------------------------------------------------------------
    logic [PC_W-1:0]   prod_c;
    logic [CORR_W-1:0] corr_next, corr_reg;
    logic              c_valid_reg, c_bad_reg;
    logic [EW-1:0]     c_energy_reg;

    always_comb begin
        prod_c    = PC_W'(f1_reg) * PC_W'(f2_reg) + (PC_W'(1) << 29);
        corr_next = prod_c[30 +: CORR_W];
    end

    // ---------------------------------------------------------------
    // Stage R: corrected energy, zero for a bad location, else rounded and saturated
    // ---------------------------------------------------------------
    logic [PE_W-1:0] prod_e, rnd_e;
    logic [EW-1:0]   energy_next, r_energy_reg;
    logic            r_bad_reg;

    always_comb begin
        prod_e = PE_W'(c_energy_reg) * PE_W'(corr_reg) + (PE_W'(1) << 29);
        rnd_e  = prod_e >> 30;
        if (c_bad_reg) begin
            energy_next = '0;
        end else if (rnd_e > PE_W'({EW{1'b1}})) begin
            energy_next = '1;
        end else begin
            energy_next = rnd_e[EW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end else if (en) begin
            f_valid_reg <= dl_valid_reg[DECAY_LAT-1];
            c_valid_reg <= f_valid_reg;
            r_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_reg       <= f1_next;
            f2_reg       <= f2_next;
            f_bad_reg    <= dl_tail.bad;
            f_energy_reg <= dl_tail.energy;
            corr_reg     <= corr_next;
            c_bad_reg    <= f_bad_reg;
            c_energy_reg <= f_energy_reg;
            r_energy_reg <= energy_next;
            r_bad_reg    <= c_bad_reg;
        end
    end

    // ---------------------------------------------------------------
    // Output buffer
    // ---------------------------------------------------------------
    logic [RES_W-1:0] res_data;

    cesc_out_skid #(.WIDTH(RES_W)) u_out_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (en && r_valid_reg),
        .push_data ({r_bad_reg, r_energy_reg}),
        .full      (buf_full),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (res_data)
    );

    assign m_tdata = M_TDATA_W'(res_data[EW-1:0]);
    assign m_tuser = res_data[EW];

    `CESC_ASSERT_IMP(a_bad_gives_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == '0)
    `CESC_ASSERT_NXT(a_tail_lands, aclk, aresetn, r_valid_reg && s_tready, m_tvalid)

endmodule

`default_nettype wire
